// File: design/ramts_pkg.sv
// ramts_pkg: shared types, codes and defaults for the range add / min search block
// no dependencies

package ramts_pkg;

    localparam int MAX_LEAVES_DEF = 1024;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OP_W   = 2;
    localparam int POS_W  = 11;
    localparam int CFG_W  = 11;
    localparam int FIDX_W = 11;

    localparam logic [CFG_W-1:0] USED_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_APPEND = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic init_wr;
        logic load;
        logic rd;
        logic modify;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic stop;
        logic op_none;
        logic out_free;
    } t_sts;

endpackage

// File: design/ramts_req_if.sv
// ramts_req_if: request channel (opcode, position) with valid/ready
// depends on ramts_pkg

interface ramts_req_if;
    logic                          valid;
    logic                          ready;
    logic [ramts_pkg::OP_W-1:0]    opcode;
    logic [ramts_pkg::POS_W-1:0]   position;

    modport source (output valid, output opcode, output position, input ready);
    modport sink   (input valid, input opcode, input position, output ready);
endinterface

// File: design/ramts_rsp_if.sv
// ramts_rsp_if: result channel (found_index, found_negative) with valid/ready
// depends on ramts_pkg

interface ramts_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ramts_pkg::FIDX_W-1:0]  found_index;
    logic                          found_negative;

    modport source (output valid, output found_index, output found_negative, input ready);
    modport sink   (input valid, input found_index, input found_negative, output ready);
endinterface

// File: design/ramts_ram.sv
// ramts_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module ramts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ramts_ctrl.sv
// ramts_ctrl: sequencer for reload sweep, leaf walk and result hand-off
// depends on ramts_pkg

module ramts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_valid,
    input  ramts_pkg::t_sts i_sts,
    output logic            o_ready,
    output ramts_pkg::t_cmd o_cmd
);

    ramts_pkg::t_state r_state;
    ramts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ramts_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ramts_pkg::S_INIT: begin
                if (i_sts.init_last) n_state = ramts_pkg::S_IDLE;
            end
            ramts_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.op_none ? ramts_pkg::S_DONE : ramts_pkg::S_READ;
                end
            end
            ramts_pkg::S_READ: n_state = ramts_pkg::S_MOD;
            ramts_pkg::S_MOD: begin
                n_state = i_sts.stop ? ramts_pkg::S_DONE : ramts_pkg::S_READ;
            end
            ramts_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = ramts_pkg::S_IDLE;
            end
            default: n_state = ramts_pkg::S_INIT;
        endcase
        // a register write restarts the reload sweep
        if (i_cfg_we) n_state = ramts_pkg::S_INIT;
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ramts_pkg::S_INIT: o_cmd.init_wr = 1'b1;
            ramts_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ramts_pkg::S_READ: o_cmd.rd = 1'b1;
            ramts_pkg::S_MOD:  o_cmd.modify = 1'b1;
            ramts_pkg::S_DONE: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: design/ramts_datapath.sv
// ramts_datapath: leaf store, index walk, saturating +1/-1 and result register
// depends on ramts_pkg, ramts_ram, ramts_rsp_if

module ramts_datapath #(
    parameter int MAX_LEAVES = ramts_pkg::MAX_LEAVES_DEF,
    parameter int VALUE_BITS = ramts_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ramts_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [ramts_pkg::OP_W-1:0]       i_opcode,
    input  logic [ramts_pkg::POS_W-1:0]      i_position,
    input  ramts_pkg::t_cmd                  i_cmd,
    output ramts_pkg::t_sts                  o_sts,
    ramts_rsp_if.source                      o_rsp
);

    localparam int IW = $clog2(MAX_LEAVES);
    localparam int LW = $clog2(MAX_LEAVES + 1);
    localparam int PW = (ramts_pkg::POS_W > ramts_pkg::CFG_W) ? ramts_pkg::POS_W
                                                             : ramts_pkg::CFG_W;
    localparam int CW = (LW > PW) ? LW : PW;
    localparam int XW = (IW + 1 > ramts_pkg::FIDX_W) ? IW + 1 : ramts_pkg::FIDX_W;
    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [63:0] VMAX64 = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

    logic [ramts_pkg::CFG_W-1:0]  r_used;
    logic [IW-1:0]                r_idx;
    ramts_pkg::t_op               r_op;
    logic [ramts_pkg::FIDX_W-1:0] r_found;
    logic                         r_neg;
    logic                         r_ovalid;
    logic [ramts_pkg::FIDX_W-1:0] r_oidx;
    logic                         r_oneg;

    logic [CW-1:0]          w_used;
    logic [CW-1:0]          w_n;
    logic [CW-1:0]          w_last;
    logic [IW-1:0]          w_last_idx;
    logic [CW-1:0]          w_k;
    logic [CW-1:0]          w_s;
    logic [VALUE_BITS-1:0]  w_rdata;
    logic [VALUE_BITS-1:0]  w_inc;
    logic [VALUE_BITS-1:0]  w_dec;
    logic [VALUE_BITS-1:0]  w_init;
    logic [VALUE_BITS-1:0]  w_wdata;
    logic                   w_neg;
    logic                   w_stop;

    // clamp the leaf count to 1..MAX_LEAVES
    always_comb begin
        w_used = CW'(r_used);
        if (w_used == '0) begin
            w_n = CW'(1);
        end else if (w_used > CW'(MAX_LEAVES)) begin
            w_n = CW'(MAX_LEAVES);
        end else begin
            w_n = w_used;
        end
        w_last     = w_n - CW'(1);
        w_last_idx = w_last[IW-1:0];
        w_k = CW'(i_position);
        if (w_k > w_last) w_k = w_last;
        w_s = (w_k == '0) ? '0 : w_k - CW'(1);
    end

    assign w_init = (64'(r_idx) > VMAX64) ? VMAX : VALUE_BITS'(r_idx);
    assign w_neg  = w_rdata[VALUE_BITS-1];
    assign w_inc  = (w_rdata == VMAX) ? w_rdata : w_rdata + VALUE_BITS'(1);
    assign w_dec  = (w_rdata == VMIN) ? w_rdata : w_rdata - VALUE_BITS'(1);
    assign w_wdata = i_cmd.init_wr ? w_init :
                     (r_op == ramts_pkg::OP_DELETE) ? w_inc : w_dec;
    assign w_stop = (r_idx == w_last_idx) || ((r_op == ramts_pkg::OP_INSERT) && w_neg);

    ramts_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LEAVES)
    ) u_leaves (
        .i_clk   (i_clk),
        .i_we    (i_cmd.init_wr | i_cmd.modify),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= ramts_pkg::USED_RESET;
            r_idx  <= '0;
        end else if (i_cfg_we) begin
            r_used <= i_cfg_data;
            r_idx  <= '0;
        end else if (i_cmd.load) begin
            r_idx <= w_s[IW-1:0];
        end else if (i_cmd.init_wr || i_cmd.modify) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= ramts_pkg::t_op'(i_opcode);
            r_found <= '0;
            r_neg   <= 1'b0;
        end else if (i_cmd.modify && w_stop && (r_op == ramts_pkg::OP_INSERT)) begin
            r_found <= ramts_pkg::FIDX_W'(XW'(r_idx) + XW'(1));
            r_neg   <= w_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oidx <= r_found;
            r_oneg <= r_neg;
        end
    end

    assign o_sts.init_last = (r_idx == IW'(MAX_LEAVES - 1));
    assign o_sts.stop      = w_stop;
    assign o_sts.op_none   = (ramts_pkg::t_op'(i_opcode) == ramts_pkg::OP_NONE);
    assign o_sts.out_free  = !r_ovalid || o_rsp.ready;

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.found_index    = r_oidx;
    assign o_rsp.found_negative = r_oneg;

endmodule

// File: design/range_add_min_tree_search_top.sv
// range_add_min_tree_search_top: top level, controller plus datapath
// depends on ramts_pkg, ramts_req_if, ramts_rsp_if, ramts_ctrl, ramts_datapath
//
//  channel   dir  beat contents                      handshake
//  i_req     in   opcode[1:0], position[10:0]       valid / ready
//  o_rsp     out  found_index[10:0], found_negative valid / ready
//  cfg       in   i_cfg_data[10:0] (used_leaves)     i_cfg_we
//
// one request at a time; each leaf from the start leaf on (up to MAX_LEAVES
// leaves) is read and then written back through the single leaf RAM, and an
// unused opcode skips the walk; after reset and after every cfg write a
// reload sweep over all MAX_LEAVES leaves runs with ready low
// the result register frees the walk while a result beat is stalled

module range_add_min_tree_search_top #(
    parameter int MAX_LEAVES = ramts_pkg::MAX_LEAVES_DEF,
    parameter int VALUE_BITS = ramts_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ramts_pkg::CFG_W-1:0] i_cfg_data,
    ramts_req_if.sink                   i_req,
    ramts_rsp_if.source                 o_rsp
);

    ramts_pkg::t_cmd w_cmd;
    ramts_pkg::t_sts w_sts;

    ramts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_we (i_cfg_we),
        .i_valid  (i_req.valid),
        .i_sts    (w_sts),
        .o_ready  (i_req.ready),
        .o_cmd    (w_cmd)
    );

    ramts_datapath #(
        .MAX_LEAVES (MAX_LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (i_req.opcode),
        .i_position (i_req.position),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_rsp      (o_rsp)
    );

endmodule

// File: design/ramts_checker.sv
// ramts_checker: port-level assertions for the top level, bound in below
// depends on ramts_pkg, range_add_min_tree_search_top

module ramts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [ramts_pkg::FIDX_W-1:0] i_found_index,
    input logic                         i_found_negative
);

    // reload sweep follows reset
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_req_ready)
        else $error("ready high right after reset");

    // reload sweep follows a cfg write
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_req_ready)
        else $error("ready high right after cfg write");

    a_neg_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_found_negative) |-> (i_found_index != '0))
        else $error("negative hit with zero index");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> ($stable(i_found_index) && $stable(i_found_negative)))
        else $error("result beat changed while stalled");

endmodule

bind range_add_min_tree_search_top ramts_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cfg_we         (i_cfg_we),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_found_index    (o_rsp.found_index),
    .i_found_negative (o_rsp.found_negative)
);

// File: verif/tb_range_add_min_tree_search_top.sv
// testbench for range_add_min_tree_search_top: random and directed requests, with
// the expected results worked out by an internal leaf-row tracker
// depends on ramts_pkg, ramts_req_if, ramts_rsp_if and the design files
`timescale 1ns / 1ps

module tb_range_add_min_tree_search_top;

    localparam int NUM_LEAVES  = ramts_pkg::MAX_LEAVES_DEF;
    localparam int VBITS       = ramts_pkg::VALUE_BITS_DEF;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam logic signed [VBITS-1:0] VAL_MAX = {1'b0, {(VBITS-1){1'b1}}};
    localparam logic signed [VBITS-1:0] VAL_MIN = {1'b1, {(VBITS-1){1'b0}}};

    typedef struct packed {
        ramts_pkg::t_op                  op;
        logic [ramts_pkg::POS_W-1:0]     pos;
    } t_request;

    typedef struct packed {
        logic [ramts_pkg::FIDX_W-1:0] index;
        logic                         negative;
    } t_found;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [ramts_pkg::CFG_W-1:0] i_cfg_data;

    ramts_req_if req_if ();
    ramts_rsp_if rsp_if ();

    range_add_min_tree_search_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // tracked leaf row and leaf count
    logic signed [VBITS-1:0]     leaf_row [NUM_LEAVES];
    logic [ramts_pkg::CFG_W-1:0] used_leaves;

    t_request pending_reqs [$];
    t_found   expected_found [$];

    int send_idle_pct;
    int recv_stall_pct;
    bit pressure_go;
    bit pressure_seen;
    bit req_accepted;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int beats_in;
    int beats_out;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int active_leaves();
        if (used_leaves == 0) return 1;
        if (used_leaves > NUM_LEAVES) return NUM_LEAVES;
        return used_leaves;
    endfunction

    function automatic void reload_row();
        for (int i = 0; i < NUM_LEAVES; i++) begin
            leaf_row[i] = (i > VAL_MAX) ? VAL_MAX : VBITS'(i);
        end
    endfunction

    function automatic void add_span(int from, int to, int delta);
        logic signed [VBITS:0] sum;
        for (int i = from; i <= to; i++) begin
            sum = leaf_row[i] + delta;
            if (sum > VAL_MAX) sum = VAL_MAX;
            if (sum < VAL_MIN) sum = VAL_MIN;
            leaf_row[i] = sum[VBITS-1:0];
        end
    endfunction

    // applies one request to the tracked row and returns the expected result
    function automatic t_found search_and_update(t_request req);
        t_found res;
        int     n;
        int     last;
        int     k;
        int     start;
        int     hit;
        n     = active_leaves();
        last  = n - 1;
        k     = (req.pos > last) ? last : req.pos;
        start = (k > 0) ? k - 1 : 0;
        res   = '0;
        case (req.op)
            ramts_pkg::OP_INSERT: begin
                hit = last;
                for (int i = start; i < n; i++) begin
                    if (leaf_row[i] < 0) begin
                        hit = i;
                        res.negative = 1'b1;
                        break;
                    end
                end
                add_span(start, hit, -1);
                res.index = ramts_pkg::FIDX_W'(hit + 1);
            end
            ramts_pkg::OP_DELETE: add_span(start, last, 1);
            ramts_pkg::OP_APPEND: add_span(start, last, -1);
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // request beat taken at the last rising edge
    always @(posedge i_clk) begin
        req_accepted <= req_if.valid && req_if.ready;
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_accepted) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                req_if.valid    <= 1'b1;
                req_if.opcode   <= pending_reqs[0].op;
                req_if.position <= pending_reqs[0].pos;
                void'(pending_reqs.pop_front());
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (pressure_go && !pressure_seen) begin
            pressure_seen <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            rsp_if.ready  <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predicts on accepted request beats, checks result beats
    always @(posedge i_clk) begin
        t_found got;
        t_found want;
        if (!i_rst_n) begin
            used_leaves = ramts_pkg::USED_RESET;
            reload_row();
        end else begin
            if (i_cfg_we) begin
                used_leaves = i_cfg_data;
                reload_row();
            end
            if (req_if.valid && req_if.ready) begin
                expected_found.push_back(search_and_update(
                    {ramts_pkg::t_op'(req_if.opcode), req_if.position}));
                beats_in++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.found_index, rsp_if.found_negative};
                beats_out++;
                if (expected_found.size() == 0) begin
                    report_mismatch("unexpected result beat", got.index, -1);
                end else begin
                    want = expected_found.pop_front();
                    if (got.index !== want.index)
                        report_mismatch("found_index", got.index, want.index);
                    if (got.negative !== want.negative)
                        report_mismatch("found_negative", got.negative, want.negative);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_req(ramts_pkg::t_op op, int pos);
        t_request r;
        r.op  = op;
        r.pos = ramts_pkg::POS_W'(pos);
        pending_reqs.push_back(r);
    endtask

    // random request biased toward positions inside the used range
    task automatic queue_random(int count);
        int n;
        int sel;
        int pos;
        ramts_pkg::t_op op;
        n = active_leaves();
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            op  = (sel < 40) ? ramts_pkg::OP_INSERT : (sel < 63) ? ramts_pkg::OP_DELETE :
                  (sel < 95) ? ramts_pkg::OP_APPEND : ramts_pkg::OP_NONE;
            pos = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(n + 1);
            queue_req(op, pos);
        end
    endtask

    task automatic wait_drained();
        wait (pending_reqs.size() == 0 && expected_found.size() == 0 && !req_if.valid);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_leaf_count(int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ramts_pkg::CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        req_if.valid    = 1'b0;
        req_if.opcode   = ramts_pkg::OP_INSERT;
        req_if.position = '0;
        rsp_if.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        pressure_go     = 1'b0;
        pressure_seen   = 1'b0;
        hold_left       = 0;
        quiet_cycles    = 0;
        mismatches      = 0;
        beats_in        = 0;
        beats_out       = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // full-size row after reset, a few slow walks
        queue_req(ramts_pkg::OP_INSERT, 0);
        queue_req(ramts_pkg::OP_INSERT, 2047);
        queue_req(ramts_pkg::OP_DELETE, 1023);
        queue_req(ramts_pkg::OP_APPEND, 1024);
        queue_req(ramts_pkg::OP_NONE, 1000);
        queue_req(ramts_pkg::OP_INSERT, 1022);
        wait_drained();

        // 16 leaves: each opcode at the edges, then random with a long stall
        write_leaf_count(16);
        foreach (leaf_row[i]) if (i < 3) begin
            queue_req(ramts_pkg::OP_APPEND, 0);
            queue_req(ramts_pkg::OP_APPEND, 1);
        end
        queue_req(ramts_pkg::OP_INSERT, 0);
        queue_req(ramts_pkg::OP_INSERT, 1);
        queue_req(ramts_pkg::OP_INSERT, 15);
        queue_req(ramts_pkg::OP_INSERT, 16);
        queue_req(ramts_pkg::OP_DELETE, 0);
        queue_req(ramts_pkg::OP_APPEND, 2047);
        queue_req(ramts_pkg::OP_NONE, 2047);
        queue_req(ramts_pkg::OP_INSERT, 1365);
        queue_req(ramts_pkg::OP_INSERT, 682);
        queue_random(80);
        pressure_go = 1'b1;
        wait_drained();

        // single leaf, driven up and then below zero
        write_leaf_count(0);
        for (int i = 0; i < 20; i++) queue_req(ramts_pkg::OP_DELETE, $urandom_range(2047));
        for (int i = 0; i < 40; i++) queue_req(ramts_pkg::OP_APPEND, $urandom_range(2047));
        queue_req(ramts_pkg::OP_INSERT, 0);
        queue_req(ramts_pkg::OP_INSERT, 2047);
        queue_req(ramts_pkg::OP_NONE, 0);
        wait_drained();

        write_leaf_count(1);
        queue_random(10);
        wait_drained();

        set_idling(48, 0);
        write_leaf_count(5);
        queue_random(90);
        wait_drained();

        set_idling(0, 48);
        write_leaf_count(33);
        queue_random(90);
        wait_drained();

        set_idling(24, 24);
        write_leaf_count(2);
        queue_random(90);
        wait_drained();

        // count above the maximum acts as the full row
        set_idling(0, 0);
        write_leaf_count(2047);
        queue_req(ramts_pkg::OP_APPEND, 0);
        queue_req(ramts_pkg::OP_INSERT, 500);
        queue_req(ramts_pkg::OP_DELETE, 2047);
        wait_drained();

        write_leaf_count(1024);
        queue_req(ramts_pkg::OP_INSERT, 1024);
        queue_req(ramts_pkg::OP_APPEND, 7);
        wait_drained();

        repeat (50) @(posedge i_clk);
        $display("covered %0d request beats and %0d result beats over leaf counts 0 to 2047,",
                 beats_in, beats_out);
        $display("including unused opcodes, clamped positions and a long result stall");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
